[rtl/spp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spp_pkg
// shared widths, constants and the queue entry type of the pair builder
// ----------------------------------------------------------------------------
package spp_pkg;

  localparam int ID_W     = 6;   // body id width
  localparam int CNT_W    = 11;  // pair counter width
  localparam int SET_W    = 64;  // widest open set carried through the queue
  localparam int Q_DEPTH  = 2;   // entries between front and back
  localparam int Q_PTR_W  = 1;
  localparam int Q_CNT_W  = 2;

  // one queued request: the bodies to pair with, the new body, list end mark
  typedef struct packed {
    logic [SET_W-1:0] mask;
    logic [ID_W-1:0]  body_id;
    logic             list_end;
  } entry_t;

endpackage
`default_nettype wire

[rtl/spp_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spp_in_if / spp_out_if
// valid/ready channels for endpoint requests and pair results
// ----------------------------------------------------------------------------
interface spp_in_if;
  logic                     valid;
  logic                     ready;
  logic [spp_pkg::ID_W-1:0] body_id;
  logic                     is_open;
  logic                     list_end;

  modport source (output valid, output body_id, output is_open, output list_end,
                  input ready);
  modport sink (input valid, input body_id, input is_open, input list_end,
                output ready);
endinterface

interface spp_out_if;
  logic                      valid;
  logic                      ready;
  logic [spp_pkg::ID_W-1:0]  first_id;
  logic [spp_pkg::ID_W-1:0]  second_id;
  logic [spp_pkg::CNT_W-1:0] pair_number;
  logic                      last_of_run;

  modport source (output valid, output first_id, output second_id,
                  output pair_number, output last_of_run, input ready);
  modport sink (input valid, input first_id, input second_id,
                input pair_number, input last_of_run, output ready);
endinterface
`default_nettype wire

[rtl/sweep_prune_pair_builder.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sweep_prune_pair_builder
// broad-phase pair builder over a sorted stream of interval endpoints
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake      payload
//  in_ch    sink       valid/ready    body_id, is_open, list_end
//  out_ch   source     valid/ready    first_id, second_id, pair_number,
//                                     last_of_run
//
//  an endpoint request with no pairs to make stays in the front unless it ends the list
//  an opening endpoint with k open partners gives k pairs in the back:
//    the snapshot is taken off the queue, then one pair per cycle, while out_ch
//    does not stall, comes from the lowest-set-bit walk over the open set snapshot
//  a two-entry queue lets the front keep taking requests while pairs drain
//  synchronous active-low reset clears the open set, counter, queue and valid
//  out_ch stalls hold the pair register; the walk waits for it to free up
//
module sweep_prune_pair_builder #(
  parameter int MAX_BODIES = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  spp_in_if.sink    in_ch,
  spp_out_if.source out_ch
);

  // front to queue
  logic             push;
  spp_pkg::entry_t  push_entry;
  logic             q_full;

  // queue to back
  spp_pkg::entry_t  head;
  logic             q_valid;
  logic             pop;

  // front keeps the open set and decides which requests need pairing
  spp_front #(
    .MAX_BODIES (MAX_BODIES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // snapshots waiting for the pair walk
  spp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_valid    (q_valid),
    .q_full     (q_full)
  );

  // back walks each snapshot and owns the running pair counter
  spp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .q_valid (q_valid),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

[rtl/spp_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spp_front
// accepts endpoints, keeps the open set, queues snapshots that need pairing
// ----------------------------------------------------------------------------
module spp_front #(
  parameter int MAX_BODIES = 64
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  spp_in_if.sink              in_ch,
  input  wire logic           q_full,
  output logic                push,
  output spp_pkg::entry_t     push_entry
);

  localparam logic [spp_pkg::ID_W:0] RANGE_LIM = (spp_pkg::ID_W+1)'(MAX_BODIES);

  logic [MAX_BODIES-1:0] open_set_r, open_set_nxt;
  logic [MAX_BODIES-1:0] self_bit;
  logic [MAX_BODIES-1:0] others;
  logic                  in_range;
  logic                  accept;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign in_range    = {1'b0, in_ch.body_id} < RANGE_LIM;

  always_comb begin
    for (int i = 0; i < MAX_BODIES; i++) begin
      self_bit[i] = (in_ch.body_id == spp_pkg::ID_W'(i));
    end
  end

  // bodies open before this one, never the body itself
  assign others = (in_range && in_ch.is_open) ? (open_set_r & ~self_bit) : '0;

  always_comb begin
    open_set_nxt = open_set_r;
    if (accept) begin
      if (in_ch.list_end) begin
        open_set_nxt = '0;
      end else if (in_range) begin
        open_set_nxt = in_ch.is_open ? (open_set_r | self_bit) : (open_set_r & ~self_bit);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_set_r <= '0;
    end else begin
      open_set_r <= open_set_nxt;
    end
  end

  // list end must reach the back to clear the counter even without pairs
  assign push = accept && ((others != '0) || in_ch.list_end);

  always_comb begin
    push_entry                       = '0;
    push_entry.mask[MAX_BODIES-1:0]  = others;
    push_entry.body_id               = in_ch.body_id;
    push_entry.list_end              = in_ch.list_end;
  end

endmodule
`default_nettype wire

[rtl/spp_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spp_queue
// two-entry fifo between the front and the back
// ----------------------------------------------------------------------------
module spp_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire spp_pkg::entry_t  push_entry,
  input  wire logic             pop,
  output spp_pkg::entry_t       head,
  output logic                  q_valid,
  output logic                  q_full
);

  spp_pkg::entry_t                 slots_r [spp_pkg::Q_DEPTH];
  logic [spp_pkg::Q_PTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [spp_pkg::Q_CNT_W-1:0]     count_r, count_nxt;

  assign q_valid = (count_r != '0);
  assign q_full  = (count_r == spp_pkg::Q_CNT_W'(spp_pkg::Q_DEPTH));
  assign head    = slots_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule
`default_nettype wire

[rtl/spp_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spp_back
// walks a queued snapshot lowest bit first, one pair per cycle while out_ch does not stall
// ----------------------------------------------------------------------------
module spp_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire spp_pkg::entry_t head,
  input  wire logic           q_valid,
  output logic                pop,
  spp_out_if.source           out_ch
);

  logic [spp_pkg::SET_W-1:0]  mask_r;
  logic [spp_pkg::ID_W-1:0]   id_r;
  logic                       last_r;
  logic                       busy_r;
  logic [spp_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;

  logic                       out_valid_r;
  logic [spp_pkg::ID_W-1:0]   first_r, second_r;
  logic [spp_pkg::CNT_W-1:0]  number_r;
  logic                       last_run_r;

  logic [spp_pkg::SET_W-1:0]  lsb_hot;
  logic [spp_pkg::SET_W-1:0]  rest;
  logic [spp_pkg::ID_W-1:0]   lsb_idx;
  logic                       out_free;
  logic                       emit;

  // isolate and drop the lowest open body
  assign lsb_hot = mask_r & (~mask_r + 1'b1);
  assign rest    = mask_r & (mask_r - 1'b1);

  always_comb begin
    lsb_idx = '0;
    for (int i = 0; i < spp_pkg::SET_W; i++) begin
      if (lsb_hot[i]) begin
        lsb_idx = lsb_idx | spp_pkg::ID_W'(i);
      end
    end
  end

  assign out_free = !out_valid_r || out_ch.ready;
  assign emit     = busy_r && out_free;
  assign pop      = !busy_r && q_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (pop && (head.mask == '0) && head.list_end) begin
      cnt_nxt = '0;
    end else if (emit) begin
      cnt_nxt = ((rest == '0) && last_r) ? '0 : cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (pop) begin
        busy_r <= (head.mask != '0);
      end else if (emit && (rest == '0)) begin
        busy_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      mask_r <= head.mask;
      id_r   <= head.body_id;
      last_r <= head.list_end;
    end else if (emit) begin
      mask_r <= rest;
    end
    if (emit) begin
      first_r    <= lsb_idx;
      second_r   <= id_r;
      number_r   <= cnt_r;
      last_run_r <= (rest == '0);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.first_id    = first_r;
  assign out_ch.second_id   = second_r;
  assign out_ch.pair_number = number_r;
  assign out_ch.last_of_run = last_run_r;

endmodule
`default_nettype wire

[rtl/spp_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spp_checker
// port-level checks on the pair builder, bound to the top level
// ----------------------------------------------------------------------------
module spp_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [spp_pkg::ID_W-1:0]  out_first_id,
  input wire logic [spp_pkg::ID_W-1:0]  out_second_id,
  input wire logic [spp_pkg::CNT_W-1:0] out_pair_number,
  input wire logic                      out_last_of_run
);

  // nothing shown right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("pair shown right after reset");

  // a stalled pair holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_first_id)
      && $stable(out_second_id) && $stable(out_pair_number))
    else $error("stalled pair changed");

  // a body never pairs with itself
  a_no_self: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_first_id != out_second_id)
    else $error("self pair");

  // within a run the next pair follows at once, same body, higher partner
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_of_run |=> out_valid
      && out_second_id == $past(out_second_id)
      && out_first_id > $past(out_first_id)
      && out_pair_number == spp_pkg::CNT_W'($past(out_pair_number) + 1'b1))
    else $error("pair run broken");

endmodule

bind sweep_prune_pair_builder spp_checker u_spp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_first_id    (out_ch.first_id),
  .out_second_id   (out_ch.second_id),
  .out_pair_number (out_ch.pair_number),
  .out_last_of_run (out_ch.last_of_run)
);
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives sorted endpoint requests into the sweep-and-prune pair builder and
// checks every emitted pair against a local model of the open-interval set
// ----------------------------------------------------------------------------
module testbench;

  localparam int BODY_LIMIT    = 64;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 80;    // longest pair walk plus queue slack

  typedef struct {
    logic [spp_pkg::ID_W-1:0]  first_id;
    logic [spp_pkg::ID_W-1:0]  second_id;
    logic [spp_pkg::CNT_W-1:0] pair_number;
    logic                      last_of_run;
  } pair_t;

  logic clk;
  logic rst_n;

  spp_in_if  endpoint_ch ();
  spp_out_if pair_ch ();

  sweep_prune_pair_builder #(
    .MAX_BODIES(BODY_LIMIT)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (endpoint_ch),
    .out_ch(pair_ch)
  );

  // model of the sweep state
  logic [BODY_LIMIT-1:0]     open_bodies;
  logic [spp_pkg::CNT_W-1:0] pair_seq;
  pair_t                     pair_expect_q[$];

  int error_count;
  int requests_sent;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_len;
  int hold_reqs;    // bumped once per long receiver hold-off
  int unsigned cycle_count;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench: FAIL");
    $finish;
  end

  task automatic report_error(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // expected pairs for one accepted endpoint request
  function automatic void predict_endpoint(input logic [spp_pkg::ID_W-1:0] id,
                                           input bit opening, input bit last);
    logic [BODY_LIMIT-1:0] partners;
    int remaining;
    int k;
    pair_t p;
    if (int'(id) < BODY_LIMIT) begin
      if (opening) begin
        // never pair a body with itself, even on a repeated open
        partners = open_bodies & ~({{(BODY_LIMIT-1){1'b0}}, 1'b1} << id);
        remaining = $countones(partners);
        for (k = 0; k < BODY_LIMIT; k++) begin
          if (partners[k]) begin
            remaining--;
            p.first_id    = k[spp_pkg::ID_W-1:0];
            p.second_id   = id;
            p.pair_number = pair_seq;
            p.last_of_run = (remaining == 0);
            pair_expect_q.insert(pair_expect_q.size(), p);
            pair_seq++;   // wraps at the counter width
          end
        end
        open_bodies[id] = 1'b1;
      end else begin
        open_bodies[id] = 1'b0;
      end
    end
    // list end clears after the pairs of this request
    if (last) begin
      open_bodies = '0;
      pair_seq    = '0;
    end
  endfunction

  // one request on the endpoint channel, with an optional idle gap first
  task automatic send_request(input logic [spp_pkg::ID_W-1:0] id, input bit opening,
                              input bit last);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      endpoint_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    endpoint_ch.valid    <= 1'b1;
    endpoint_ch.body_id  <= id;
    endpoint_ch.is_open  <= opening;
    endpoint_ch.list_end <= last;
    do @(posedge clk); while (!endpoint_ch.ready);
    predict_endpoint(id, opening, last);
    requests_sent++;
  endtask

  // sender stops and waits for every outstanding pair
  task automatic drain_pairs();
    endpoint_ch.valid <= 1'b0;
    @(posedge clk);
    while (pair_expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic check_pair();
    pair_t want;
    if (pair_expect_q.size() == 0) begin
      report_error($sformatf("pair (%0d,%0d) #%0d with nothing expected",
                             pair_ch.first_id, pair_ch.second_id, pair_ch.pair_number));
    end else begin
      want = pair_expect_q.pop_front();
      if (pair_ch.first_id !== want.first_id)
        report_error($sformatf("first_id %0d, expected %0d", pair_ch.first_id,
                               want.first_id));
      if (pair_ch.second_id !== want.second_id)
        report_error($sformatf("second_id %0d, expected %0d", pair_ch.second_id,
                               want.second_id));
      if (pair_ch.pair_number !== want.pair_number)
        report_error($sformatf("pair_number %0d, expected %0d", pair_ch.pair_number,
                               want.pair_number));
      if (pair_ch.last_of_run !== want.last_of_run)
        report_error($sformatf("last_of_run %0b, expected %0b", pair_ch.last_of_run,
                               want.last_of_run));
    end
  endtask

  // pair receiver: checks on each handshake, then decides ready for the next edge
  initial begin : pair_sink
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    pair_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && pair_ch.valid && pair_ch.ready) check_pair();
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        pair_ch.ready <= 1'b0;
      end else begin
        pair_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // corner cases by hand: empty set, id extremes, reopen, stray close, list end
  task automatic test_directed();
    send_request(6'd0, 1'b1, 1'b0);    // nothing open yet, no pairs
    send_request(6'd63, 1'b1, 1'b0);   // (0,63)
    send_request(6'd63, 1'b1, 1'b0);   // reopen: pairs with 0 only, not itself
    send_request(6'd5, 1'b0, 1'b0);    // close of a body never opened
    send_request(6'd21, 1'b1, 1'b0);   // (0,21) (63,21)
    send_request(6'd0, 1'b0, 1'b0);
    send_request(6'd42, 1'b1, 1'b1);   // pairs first, then the list clears
    send_request(6'd7, 1'b1, 1'b0);    // fresh list, no pairs
    send_request(6'd7, 1'b0, 1'b1);    // closing request ends the list
    send_request(6'd1, 1'b1, 1'b0);
    send_request(6'd2, 1'b1, 1'b0);
    send_request(6'd3, 1'b1, 1'b0);
    send_request(6'd2, 1'b0, 1'b0);
    send_request(6'd62, 1'b1, 1'b0);   // skips the closed body
    send_request(6'd63, 1'b0, 1'b0);   // stale id from the previous list
    send_request(6'd1, 1'b0, 1'b0);
    send_request(6'd3, 1'b0, 1'b0);
    send_request(6'd62, 1'b0, 1'b1);
    send_request(6'd42, 1'b0, 1'b1);   // list end on an empty set
    send_request(6'd63, 1'b1, 1'b1);   // open with list end and nothing to pair
  endtask

  // every body open at once: runs of 63 pairs and a counter rollover
  task automatic test_full_list_wrap();
    logic [spp_pkg::ID_W-1:0] order[BODY_LIMIT];
    logic [spp_pkg::ID_W-1:0] tmp;
    int i;
    int j;
    for (i = 0; i < BODY_LIMIT; i++) order[i] = i[spp_pkg::ID_W-1:0];
    for (i = BODY_LIMIT - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = order[i]; order[i] = order[j]; order[j] = tmp;
    end
    for (i = 0; i < BODY_LIMIT; i++) send_request(order[i], 1'b1, 1'b0);
    // one more reopen pushes the count past the counter range
    send_request(order[$urandom_range(BODY_LIMIT - 1)], 1'b1, 1'b0);
    for (i = BODY_LIMIT - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = order[i]; order[i] = order[j]; order[j] = tmp;
    end
    for (i = 0; i < BODY_LIMIT; i++) send_request(order[i], 1'b0, i == BODY_LIMIT - 1);
  endtask

  // receiver holds off while reopens keep piling up pairs behind the queue
  task automatic test_output_backpressure();
    logic [spp_pkg::ID_W-1:0] group[$];
    logic [spp_pkg::ID_W-1:0] id;
    logic [BODY_LIMIT-1:0] used;
    int i;
    used = '0;
    while (group.size() < 8) begin
      id = spp_pkg::ID_W'($urandom_range(BODY_LIMIT - 1));
      if (!used[id]) begin
        used[id] = 1'b1;
        group.insert(group.size(), id);
      end
    end
    hold_len  <= 400;
    hold_reqs <= hold_reqs + 1;
    foreach (group[i]) send_request(group[i], 1'b1, 1'b0);
    for (i = 0; i < 12; i++) send_request(group[$urandom_range(group.size() - 1)], 1'b1, 1'b0);
    foreach (group[i]) send_request(group[i], 1'b0, i == group.size() - 1);
  endtask

  // one sorted list of distinct bodies; a broken list gets stray requests
  // and may end early with bodies still open
  task automatic send_random_list(input bit broken);
    logic [spp_pkg::ID_W-1:0] pending[$];
    logic [spp_pkg::ID_W-1:0] live[$];
    logic [BODY_LIMIT-1:0] used;
    logic [spp_pkg::ID_W-1:0] id;
    bit opening;
    bit last;
    int n_bodies;
    int pick;
    int total;
    int step;
    used = '0;
    n_bodies = ($urandom_range(15) == 0) ? $urandom_range(11, 40) : $urandom_range(2, 10);
    while (pending.size() < n_bodies) begin
      id = spp_pkg::ID_W'($urandom_range(BODY_LIMIT - 1));
      if (!used[id]) begin
        used[id] = 1'b1;
        pending.insert(pending.size(), id);
      end
    end
    total = 2 * n_bodies;
    for (step = 0; step < total; step++) begin
      if (pending.size() != 0 && (live.size() == 0 || $urandom_range(99) < 60)) begin
        id = pending.pop_front();
        live.insert(live.size(), id);
        opening = 1'b1;
      end else begin
        pick = $urandom_range(live.size() - 1);
        id = live[pick];
        live.delete(pick);
        opening = 1'b0;
      end
      last = (step == total - 1);
      if (broken && $urandom_range(5) == 0) begin
        id      = spp_pkg::ID_W'($urandom_range(BODY_LIMIT - 1));
        opening = 1'($urandom_range(1));
      end
      if (broken && $urandom_range(15) == 0) last = 1'b1;
      send_request(id, opening, last);
      if (last) break;
    end
  endtask

  task automatic test_random_traffic(input int target);
    int roll;
    int n;
    while (requests_sent < target) begin
      roll = $urandom_range(99);
      if (roll < 70) begin
        send_random_list(1'b0);
      end else if (roll < 85) begin
        send_random_list(1'b1);
      end else begin
        // unstructured requests with an occasional list end
        for (n = $urandom_range(1, 4); n > 0; n--)
          send_request(spp_pkg::ID_W'($urandom_range(BODY_LIMIT - 1)),
                       1'($urandom_range(1)), $urandom_range(7) == 0);
      end
    end
  endtask

  initial begin
    error_count   = 0;
    requests_sent = 0;
    hold_len      = 0;
    hold_reqs     = 0;
    open_bodies   = '0;
    pair_seq      = '0;
    send_idle_pct = 33;
    recv_idle_pct = 52;
    rst_n                = 1'b0;
    endpoint_ch.valid    = 1'b0;
    endpoint_ch.body_id  = '0;
    endpoint_ch.is_open  = 1'b0;
    endpoint_ch.list_end = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // sender idles more rarely than the receiver
    test_directed();
    test_full_list_wrap();
    test_random_traffic(requests_sent + 40);
    drain_pairs();

    // roles swapped
    send_idle_pct = 52;
    recv_idle_pct = 33;
    test_output_backpressure();
    drain_pairs();
    test_random_traffic(requests_sent + 40);
    drain_pairs();

    // full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(requests_sent + 40);
    drain_pairs();

    // catch any stray pair after the last expected one
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
